[hw/rtl/tgarle_pkg.sv]
`default_nettype none

package tgarle_pkg;

   localparam logic [7:0] RUN_HDR_MIN = 8'd128;
   localparam logic [7:0] RUN_HDR_BIAS = 8'd127;
   localparam logic [7:0] BPP_24 = 8'd24;
   localparam logic [7:0] BPP_32 = 8'd32;

   localparam int unsigned RSP_DATA_W = 40;
   localparam int unsigned RSP_USER_W = 2;

   typedef enum logic [1:0] {
      CSR_RLE_MODE = 2'd0,
      CSR_IMAGE_WIDTH = 2'd1,
      CSR_IMAGE_HEIGHT = 2'd2,
      CSR_BITS_PER_PIXEL = 2'd3
   } csr_idx_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0,
      ST_BAD_CFG = 2'd1,
      ST_OVERFLOW = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic [7:0] span_length;
      logic last_of_image;
      status_type status;
   } result_type;

   typedef struct packed {
      logic stopped;
      logic cfg_bad;
   } core_stat_type;

endpackage

`default_nettype wire

[hw/rtl/tgarle_core.sv]
`default_nettype none

module tgarle_core
   import tgarle_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic csr_wen,
   input wire logic [1:0] csr_index,
   input wire logic [15:0] csr_wdata,
   input wire logic fire,
   input wire logic [7:0] in_byte,
   output logic res_valid,
   output result_type res,
   output core_stat_type stat
);

   logic rle_ff, rle_in;
   logic [15:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic [7:0] bpp_ff, bpp_in;

   logic expect_hdr_ff, expect_hdr_in;
   logic run_pkt_ff, run_pkt_in;
   logic [7:0] pkt_left_ff, pkt_left_in;
   logic [1:0] bip_ff, bip_in;
   logic [23:0] color_ff, color_in;
   logic [31:0] img_left_ff, img_left_in;
   logic stopped_ff, stopped_in;

   logic restart;
   logic cfg_bad;
   logic is32;
   logic store_byte;
   logic more_in_pkt;
   logic [7:0] span;
   logic [7:0] pkt_dec;
   logic [31:0] span_wide;
   logic clip;
   logic [7:0] span_clip;
   logic [31:0] left_after;

   assign cfg_bad = (width_ff == 16'd0) || (height_ff == 16'd0) ||
                    ((bpp_ff != BPP_24) && (bpp_ff != BPP_32));
   assign is32 = (bpp_ff == BPP_32);
   assign store_byte = bip_ff < (is32 ? 2'd3 : 2'd2);
   assign pkt_dec = (pkt_left_ff != 8'd0) ? pkt_left_ff - 8'd1 : 8'd0;

   always_comb begin
      if (!rle_ff) begin
         span = 8'd1;
         more_in_pkt = 1'b0;
      end else if (run_pkt_ff) begin
         span = pkt_left_ff;
         more_in_pkt = 1'b0;
      end else begin
         span = 8'd1;
         more_in_pkt = (pkt_dec != 8'd0);
      end
   end

   assign span_wide = {24'd0, span};
   assign clip = span_wide > img_left_ff;
   assign span_clip = clip ? img_left_ff[7:0] : span;
   assign left_after = img_left_ff - {24'd0, span_clip};

   always_comb begin
      rle_in = rle_ff;
      width_in = width_ff;
      height_in = height_ff;
      bpp_in = bpp_ff;
      restart = 1'b0;
      if (csr_wen) begin
         case (csr_idx_type'(csr_index))
            CSR_RLE_MODE: begin
               rle_in = csr_wdata[0];
               restart = 1'b1;
            end
            CSR_IMAGE_WIDTH: begin
               width_in = csr_wdata;
               restart = 1'b1;
            end
            CSR_IMAGE_HEIGHT: begin
               height_in = csr_wdata;
               restart = 1'b1;
            end
            CSR_BITS_PER_PIXEL: begin
               bpp_in = csr_wdata[7:0];
               restart = 1'b1;
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      expect_hdr_in = expect_hdr_ff;
      run_pkt_in = run_pkt_ff;
      pkt_left_in = pkt_left_ff;
      bip_in = bip_ff;
      color_in = color_ff;
      img_left_in = img_left_ff;
      stopped_in = stopped_ff;
      res_valid = 1'b0;
      res = '0;
      if (restart) begin
         expect_hdr_in = rle_in;
         run_pkt_in = 1'b0;
         pkt_left_in = 8'd0;
         bip_in = 2'd0;
         color_in = 24'd0;
         img_left_in = {16'd0, width_in} * {16'd0, height_in};
         stopped_in = 1'b0;
      end else if (fire && !stopped_ff) begin
         if (cfg_bad) begin
            stopped_in = 1'b1;
            res_valid = 1'b1;
            res.last_of_image = 1'b1;
            res.status = ST_BAD_CFG;
         end else if (rle_ff && expect_hdr_ff) begin
            expect_hdr_in = 1'b0;
            if (in_byte < RUN_HDR_MIN) begin
               run_pkt_in = 1'b0;
               pkt_left_in = in_byte + 8'd1;
            end else begin
               run_pkt_in = 1'b1;
               pkt_left_in = in_byte - RUN_HDR_BIAS;
            end
         end else if (store_byte) begin
            case (bip_ff)
               2'd0: color_in[7:0] = in_byte;
               2'd1: color_in[15:8] = in_byte;
               default: color_in[23:16] = in_byte;
            endcase
            bip_in = bip_ff + 2'd1;
         end else begin
            bip_in = 2'd0;
            if (rle_ff) begin
               if (run_pkt_ff) begin
                  pkt_left_in = 8'd0;
                  expect_hdr_in = 1'b1;
               end else begin
                  pkt_left_in = pkt_dec;
                  expect_hdr_in = (pkt_dec == 8'd0);
               end
            end
            img_left_in = left_after;
            res_valid = 1'b1;
            res.blue = color_ff[7:0];
            res.green = color_ff[15:8];
            res.red = is32 ? color_ff[23:16] : in_byte;
            res.alpha = is32 ? in_byte : 8'd0;
            res.span_length = span_clip;
            res.status = clip ? ST_OVERFLOW : ST_OK;
            if (left_after == 32'd0) begin
               res.last_of_image = 1'b1;
               stopped_in = 1'b1;
               if (rle_ff && more_in_pkt) begin
                  res.status = ST_OVERFLOW;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rle_ff <= 1'b1;
         width_ff <= 16'd1;
         height_ff <= 16'd1;
         bpp_ff <= BPP_24;
         expect_hdr_ff <= 1'b1;
         run_pkt_ff <= 1'b0;
         pkt_left_ff <= 8'd0;
         bip_ff <= 2'd0;
         color_ff <= 24'd0;
         img_left_ff <= 32'd1;
         stopped_ff <= 1'b0;
      end else begin
         rle_ff <= rle_in;
         width_ff <= width_in;
         height_ff <= height_in;
         bpp_ff <= bpp_in;
         expect_hdr_ff <= expect_hdr_in;
         run_pkt_ff <= run_pkt_in;
         pkt_left_ff <= pkt_left_in;
         bip_ff <= bip_in;
         color_ff <= color_in;
         img_left_ff <= img_left_in;
         stopped_ff <= stopped_in;
      end
   end

   assign stat.stopped = stopped_ff;
   assign stat.cfg_bad = cfg_bad;

endmodule

`default_nettype wire

[hw/rtl/tgarle_out_reg.sv]
`default_nettype none

module tgarle_out_reg
   import tgarle_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic fire,
   input wire logic res_valid,
   input wire result_type res,
   output logic advance,
   output logic rsp_tvalid,
   input wire logic rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic rsp_tlast,
   output logic [RSP_USER_W-1:0] rsp_tuser
);

   logic valid_ff, valid_in;
   result_type res_ff, res_in;

   assign advance = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      res_in = res_ff;
      if (advance) begin
         valid_in = fire && res_valid;
      end
      if (fire && res_valid) begin
         res_in = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      res_ff <= res_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata = {res_ff.span_length, res_ff.alpha, res_ff.blue, res_ff.green, res_ff.red};
   assign rsp_tlast = res_ff.last_of_image;
   assign rsp_tuser = res_ff.status;

endmodule

`default_nettype wire

[hw/rtl/tga_rle_pixel_decoder.sv]
// Pixel decoder for the image area of 24 or 32 bit run-length or plain TGA files.
// The req channel takes the pixel stream one byte per transaction. The rsp
// channel gives one transaction per raw pixel, or one per run packet with the
// run length in span_length; the receiver expands runs. tlast marks the span
// that completes width*height pixels or reports a bad configuration, after
// which all bytes are dropped until reset or a register write.
// Registers must be written through csr_ while no byte is in flight; the block
// does not enforce this. Any write restarts a new image with the new values.
// Throughput is one byte per clock while the receiver takes results. A byte
// is held in the input register; the core decodes it combinationally, and
// the output register holds the result and offers it on rsp.
// Reset selects run-length mode, a 1x1 image and 24-bit pixels. When the
// receiver stalls, the output register holds its result and the input
// register takes one more byte only if it is empty, then req_tready drops.
`default_nettype none

module tga_rle_pixel_decoder
   import tgarle_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tvalid,
   output logic req_tready,
   input wire logic [7:0] req_tdata,                 // in_byte
   output logic rsp_tvalid,
   input wire logic rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,          // red, green, blue, alpha, span_length
   output logic rsp_tlast,
   output logic [RSP_USER_W-1:0] rsp_tuser,          // status
   input wire logic csr_wen,
   input wire logic [1:0] csr_index,
   input wire logic [15:0] csr_wdata
);

   logic in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic advance;
   logic fire;
   logic res_valid;
   result_type res;
   core_stat_type stat;

   assign fire = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in = in_byte_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_byte_in = req_tdata;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_byte_ff <= in_byte_in;
   end

   tgarle_core u_core (
      .clock(clock),
      .reset(reset),
      .csr_wen(csr_wen),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .fire(fire),
      .in_byte(in_byte_ff),
      .res_valid(res_valid),
      .res(res),
      .stat(stat)
   );

   tgarle_out_reg u_out_reg (
      .clock(clock),
      .reset(reset),
      .fire(fire),
      .res_valid(res_valid),
      .res(res),
      .advance(advance),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .rsp_tuser(rsp_tuser)
   );

   a_stopped_quiet: assert property (@(posedge clock) disable iff (reset)
      stat.stopped |-> !res_valid)
      else $error("result produced while decoder is stopped");

   a_last_stops: assert property (@(posedge clock) disable iff (reset)
      (fire && res_valid && res.last_of_image && !csr_wen) |=> stat.stopped)
      else $error("decoder did not stop after final span");

   a_bad_cfg_reports: assert property (@(posedge clock) disable iff (reset)
      (fire && stat.cfg_bad && !stat.stopped && !csr_wen) |-> res_valid)
      else $error("bad configuration not reported");

   a_zero_span: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[39:32] == 8'd0) |->
         (rsp_tuser == ST_BAD_CFG && rsp_tlast))
      else $error("zero span without configuration error");

endmodule

`default_nettype wire
